// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the button debounce block.
// Shared by every RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define BDA_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BDA_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`endif

// ===== rtl/core/bda_pkg.sv =====
// Shared types, codes and delay helpers for the button debounce block.
// No dependencies.
package bda_pkg;

  localparam int DELAY_BITS = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Event codes.
  localparam logic [1:0] EV_PRESS        = 2'd0;
  localparam logic [1:0] EV_RELEASE      = 2'd1;
  localparam logic [1:0] EV_LONG_PRESS   = 2'd2;
  localparam logic [1:0] EV_LONG_RELEASE = 2'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRATOR_MAX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_REPEAT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_FACTOR   = 3'd5;

  // Largest delay value, held in 33 bits so that any delay width fits.
  localparam logic [32:0] DELAY_MAX_W = (33'd1 << DELAY_BITS) - 33'd1;

  typedef logic [DELAY_BITS-1:0] delay_t;

  typedef struct packed {
    logic [7:0]  integrator_max;
    logic        default_high;
    logic        auto_repeat;
    logic [15:0] first_delay;
    logic [15:0] min_delay;
    logic [8:0]  accel_factor;
  } cfg_t;

  typedef struct packed {
    logic   countdown_active;
    logic   held_long;
    delay_t countdown_ticks;
    delay_t repeat_delay;
  } status_t;

  // Clamp a value to the delay range.
  function automatic delay_t sat_delay(input logic [32:0] v);
    delay_t r;
    if (v > DELAY_MAX_W) begin
      r = '1;
    end else begin
      r = v[DELAY_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/button_debounce_autorepeat_top.sv =====
// Button debouncer with long press and auto-repeat. Each request on the
// input stream is one sample tick of the raw pin; it produces zero or one
// event request on the output stream (press, release, long press, long
// release). One sample is taken every cycle: the whole update, including
// the single delay multiply, runs between the state registers and the
// output register, so throughput is one sample per clock and an event
// appears in the cycle after its sample. Input stalls only while an event
// waits in the output register and the sink is not ready.
`include "assert_macros.svh"

module button_debounce_autorepeat_top (
  input  logic                            clk,
  input  logic                            rst,
  // Sample stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [0] pin_level, [7:1] zero
  // Event stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [1:0] event_res, [7:2] zero
  // Register write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bda_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bda_pkg::cfg_t    cfg;
  bda_pkg::status_t status;
  logic             step;
  logic             evt_valid;
  logic [1:0]       evt_code;
  logic [1:0]       event_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.integrator_max <= 8'd5;
      cfg.default_high   <= 1'b0;
      cfg.auto_repeat    <= 1'b0;
      cfg.first_delay    <= 16'd500;
      cfg.min_delay      <= 16'd50;
      cfg.accel_factor   <= 9'd205;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bda_pkg::REG_INTEGRATOR_MAX: cfg.integrator_max <= cfg_data[7:0];
        bda_pkg::REG_DEFAULT_HIGH:   cfg.default_high   <= cfg_data[0];
        bda_pkg::REG_AUTO_REPEAT:    cfg.auto_repeat    <= cfg_data[0];
        bda_pkg::REG_FIRST_DELAY:    cfg.first_delay    <= cfg_data[15:0];
        bda_pkg::REG_MIN_DELAY:      cfg.min_delay      <= cfg_data[15:0];
        bda_pkg::REG_ACCEL_FACTOR:   cfg.accel_factor   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  bda_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pin_level (s_tdata[0]),
    .cfg       (cfg),
    .evt_valid (evt_valid),
    .evt_code  (evt_code),
    .status    (status)
  );

  // Output register: loaded on a sample that makes an event, freed when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= evt_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && evt_valid) begin
      event_res <= evt_code;
    end
  end

  assign m_tdata = {6'd0, event_res};

  `BDA_ASSERT(a_active_ticks, clk, rst, status.countdown_active |-> (status.countdown_ticks != '0), "countdown active with zero ticks")
  `BDA_ASSERT(a_idle_ticks, clk, rst, !status.countdown_active |-> (status.countdown_ticks == '0), "stopped countdown holds ticks")
  `BDA_ASSERT(a_active_delay, clk, rst, status.countdown_active |-> (status.repeat_delay != '0), "countdown active with zero delay")
  `BDA_ASSERT_ALWAYS(a_stall_cause, clk, !s_tready |-> (m_tvalid && !m_tready), "input stalled without a waiting event")

endmodule

// ===== rtl/core/bda_integrator.sv =====
// Saturating up/down integrator that turns raw pin samples into a level.
// No dependencies.
module bda_integrator (
  input  logic [7:0] count,
  input  logic [7:0] count_max,
  input  logic       pin_level,
  input  logic       stable_level,
  output logic [7:0] count_next,
  output logic       level
);

  logic [8:0] up;

  assign up = {1'b0, count} + 9'd1;

  always_comb begin
    count_next = count;
    level      = stable_level;
    if (pin_level) begin
      if (up >= {1'b0, count_max}) begin
        count_next = count_max;
        level      = 1'b1;
      end else begin
        count_next = up[7:0];
      end
    end else if (count <= 8'd1) begin
      count_next = '0;
      level      = 1'b0;
    end else if ((count - 8'd1) >= count_max) begin
      // The maximum was lowered below the count.
      count_next = count_max;
      level      = 1'b1;
    end else begin
      count_next = count - 8'd1;
    end
  end

endmodule

// ===== rtl/core/bda_delay_calc.sv =====
// Delay arithmetic: first delay load and the accelerated repeat delay.
// Depends on bda_pkg.
module bda_delay_calc (
  input  bda_pkg::cfg_t   cfg,
  input  bda_pkg::delay_t repeat_delay,
  output bda_pkg::delay_t first_load,
  output bda_pkg::delay_t repeat_next
);

  localparam int PROD_W = bda_pkg::DELAY_BITS + 9;

  logic [PROD_W-1:0]   prod;
  bda_pkg::delay_t     scaled;
  bda_pkg::delay_t     floor_v;
  bda_pkg::delay_t     first_sat;
  bda_pkg::delay_t     raised;

  assign prod      = PROD_W'(repeat_delay) * PROD_W'(cfg.accel_factor);
  assign scaled    = bda_pkg::sat_delay(33'(prod[PROD_W-1:8]));
  assign floor_v   = bda_pkg::sat_delay(33'(cfg.min_delay));
  assign raised    = (scaled < floor_v) ? floor_v : scaled;
  assign repeat_next = (raised == '0) ? bda_pkg::delay_t'(1) : raised;

  assign first_sat  = bda_pkg::sat_delay(33'(cfg.first_delay));
  assign first_load = (first_sat == '0) ? bda_pkg::delay_t'(1) : first_sat;

endmodule

// ===== rtl/core/bda_core.sv =====
// Per-sample state update: integrator, level change and countdown events.
// Depends on bda_pkg, bda_integrator and bda_delay_calc.
module bda_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               pin_level,
  input  bda_pkg::cfg_t      cfg,
  output logic               evt_valid,
  output logic [1:0]         evt_code,
  output bda_pkg::status_t   status
);

  logic [7:0]      integrator_count, integrator_count_next;
  logic            stable_level, stable_level_next;
  logic            held_long, held_long_next;
  logic            countdown_active, countdown_active_next;
  bda_pkg::delay_t countdown_ticks, countdown_ticks_next;
  bda_pkg::delay_t repeat_delay, repeat_delay_next;

  logic            level;
  bda_pkg::delay_t first_load;
  bda_pkg::delay_t repeat_next;
  bda_pkg::delay_t ticks_dec;

  bda_integrator u_integrator (
    .count        (integrator_count),
    .count_max    (cfg.integrator_max),
    .pin_level    (pin_level),
    .stable_level (stable_level),
    .count_next   (integrator_count_next),
    .level        (level)
  );

  bda_delay_calc u_delay_calc (
    .cfg          (cfg),
    .repeat_delay (repeat_delay),
    .first_load   (first_load),
    .repeat_next  (repeat_next)
  );

  assign ticks_dec = (countdown_ticks != '0) ? (countdown_ticks - 1'b1) : countdown_ticks;

  always_comb begin
    stable_level_next     = stable_level;
    held_long_next        = held_long;
    countdown_active_next = countdown_active;
    countdown_ticks_next  = countdown_ticks;
    repeat_delay_next     = repeat_delay;
    evt_valid             = 1'b0;
    evt_code              = bda_pkg::EV_PRESS;
    if (level != stable_level) begin
      // A level change wins over a countdown expiry in the same sample.
      stable_level_next = level;
      held_long_next    = 1'b0;
      evt_valid         = 1'b1;
      if (level != cfg.default_high) begin
        repeat_delay_next     = first_load;
        countdown_ticks_next  = first_load;
        countdown_active_next = 1'b1;
        evt_code              = bda_pkg::EV_PRESS;
      end else begin
        countdown_active_next = 1'b0;
        countdown_ticks_next  = '0;
        evt_code = held_long ? bda_pkg::EV_LONG_RELEASE : bda_pkg::EV_RELEASE;
      end
    end else if (countdown_active) begin
      countdown_ticks_next = ticks_dec;
      if (ticks_dec == '0) begin
        held_long_next = 1'b1;
        evt_valid      = 1'b1;
        if (cfg.auto_repeat) begin
          repeat_delay_next    = repeat_next;
          countdown_ticks_next = repeat_next;
          evt_code             = bda_pkg::EV_PRESS;
        end else begin
          countdown_active_next = 1'b0;
          evt_code              = bda_pkg::EV_LONG_PRESS;
        end
      end
    end
  end

  // After reset the state follows the reset register values: idle low, count zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator_count <= '0;
      stable_level     <= 1'b0;
      held_long        <= 1'b0;
      countdown_active <= 1'b0;
      countdown_ticks  <= '0;
      repeat_delay     <= '0;
    end else if (step) begin
      integrator_count <= integrator_count_next;
      stable_level     <= stable_level_next;
      held_long        <= held_long_next;
      countdown_active <= countdown_active_next;
      countdown_ticks  <= countdown_ticks_next;
      repeat_delay     <= repeat_delay_next;
    end
  end

  assign status.countdown_active = countdown_active;
  assign status.held_long        = held_long;
  assign status.countdown_ticks  = countdown_ticks;
  assign status.repeat_delay     = repeat_delay;

endmodule
